/* design/assert_macros.svh */
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; they compile away under synthesis.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)
`endif
`endif

/* design/ppds_pkg.sv */
// -----------------------------------------------------------------------------
// ppds_pkg
// Widths, codes and the per-item side band of the point-plane distance block.
// -----------------------------------------------------------------------------
package ppds_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 8;
    localparam int COEF_W      = 16;
    localparam int OFFS_W      = 40;
    localparam int TOL_W       = 20;
    localparam int VAL_W       = 42;
    localparam int MAG_W       = VAL_W - 1;
    localparam int DIST_W      = 49;
    localparam int PROD_W      = COORD_WIDTH + COEF_W;
    localparam int NORM_W      = 2 * COEF_W;
    localparam int ML_W        = (MAG_W + 1) / 2;
    localparam int MH_W        = MAG_W - ML_W;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int R_W         = SQ_W + 2 * FRAC_BITS;
    localparam int P_W         = DIST_W + NORM_W;
    localparam int T_W         = 2 * DIST_W + NORM_W + 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = OFFS_W;
    localparam int S_DATA_W    = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_W    = ((VAL_W + DIST_W + 7) / 8) * 8;
    localparam int M_USER_W    = 3;

    typedef enum logic [1:0] {
        SIDE_ON    = 2'd0,
        SIDE_ABOVE = 2'd1,
        SIDE_BELOW = 2'd2
    } side_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_A = 3'd0,
        CFG_COEF_B = 3'd1,
        CFG_COEF_C = 3'd2,
        CFG_COEF_D = 3'd3,
        CFG_TOL    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        side_t                   side;
        logic                    degen;
    } meta_t;

endpackage

/* design/ppds_dot.sv */
// -----------------------------------------------------------------------------
// ppds_dot
// Two stages: the three coordinate products, then the plane value, its
// magnitude and the side decision.
// -----------------------------------------------------------------------------
module ppds_dot
    import ppds_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic signed [COEF_W-1:0]      coef_a,
    input  logic signed [COEF_W-1:0]      coef_b,
    input  logic signed [COEF_W-1:0]      coef_c,
    input  logic signed [OFFS_W-1:0]      coef_d,
    input  logic        [TOL_W-1:0]       on_tolerance,
    output logic                          out_valid,
    output meta_t                         out_meta,
    output logic        [MAG_W-1:0]       out_mag
);

    logic                     v1_reg;
    logic signed [PROD_W-1:0] ax_reg, by_reg, cz_reg;
    logic                     degen1_reg;
    logic                     v2_reg;
    meta_t                    meta2_reg;
    logic        [MAG_W-1:0]  mag2_reg;

    logic signed [VAL_W-1:0] sum;
    logic signed [VAL_W-1:0] neg_sum;
    logic        [MAG_W-1:0] mag_next;
    meta_t                   meta_next;

    assign sum = VAL_W'(ax_reg) + VAL_W'(by_reg) + VAL_W'(cz_reg) + VAL_W'(coef_d);
    assign neg_sum = -sum;

    always_comb begin
        mag_next = sum[VAL_W-1] ? neg_sum[MAG_W-1:0] : sum[MAG_W-1:0];
        meta_next.value = sum;
        meta_next.degen = degen1_reg;
        if (mag_next <= MAG_W'(on_tolerance)) begin
            meta_next.side = SIDE_ON;
        end else if (sum[VAL_W-1]) begin
            meta_next.side = SIDE_BELOW;
        end else begin
            meta_next.side = SIDE_ABOVE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ax_reg     <= coef_a * point_x;
            by_reg     <= coef_b * point_y;
            cz_reg     <= coef_c * point_z;
            degen1_reg <= (coef_a == '0) && (coef_b == '0) && (coef_c == '0);
            meta2_reg  <= meta_next;
            mag2_reg   <= mag_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_meta  = meta2_reg;
    assign out_mag   = mag2_reg;

endmodule

/* design/ppds_sqr.sv */
// -----------------------------------------------------------------------------
// ppds_sqr
// Two stages that square the magnitude from split partial products and
// scale it by the fraction bits to form the starting remainder.
// -----------------------------------------------------------------------------
module ppds_sqr
    import ppds_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  meta_t            in_meta,
    input  logic [MAG_W-1:0] in_mag,
    output logic             out_valid,
    output meta_t            out_meta,
    output logic [R_W-1:0]   out_rem
);

    logic                   v3_reg, v4_reg;
    meta_t                  meta3_reg, meta4_reg;
    logic [2*MH_W-1:0]      hh_reg;
    logic [MH_W+ML_W-1:0]   hl_reg;
    logic [2*ML_W-1:0]      ll_reg;
    logic [R_W-1:0]         rem4_reg;

    logic [MH_W-1:0] mh;
    logic [ML_W-1:0] ml;
    logic [R_W-1:0]  rem_next;

    assign mh = in_mag[MAG_W-1:ML_W];
    assign ml = in_mag[ML_W-1:0];
    assign rem_next = (R_W'(hh_reg) << (2 * ML_W + 2 * FRAC_BITS))
                    + (R_W'(hl_reg) << (ML_W + 1 + 2 * FRAC_BITS))
                    + (R_W'(ll_reg) << (2 * FRAC_BITS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hh_reg    <= (2*MH_W)'(mh) * (2*MH_W)'(mh);
            hl_reg    <= (MH_W+ML_W)'(mh) * (MH_W+ML_W)'(ml);
            ll_reg    <= (2*ML_W)'(ml) * (2*ML_W)'(ml);
            meta3_reg <= in_meta;
            meta4_reg <= meta3_reg;
            rem4_reg  <= rem_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_meta  = meta4_reg;
    assign out_rem   = rem4_reg;

endmodule

/* design/ppds_root.sv */
// -----------------------------------------------------------------------------
// ppds_root
// One stage per quotient bit: finds the largest q with q*q*N <= remainder,
// keeping the remainder and q*N up to date with shifts and adds only.
// -----------------------------------------------------------------------------
module ppds_root
    import ppds_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic [NORM_W-1:0] norm,
    input  logic              in_valid,
    input  meta_t             in_meta,
    input  logic [R_W-1:0]    in_rem,
    output logic              out_valid,
    output meta_t             out_meta,
    output logic [DIST_W-1:0] out_dist
);

    logic              v_reg    [1:DIST_W];
    meta_t             meta_reg [1:DIST_W];
    logic [DIST_W-1:0] q_reg    [1:DIST_W];
    logic [R_W-1:0]    r_reg    [1:DIST_W-1];
    logic [P_W-1:0]    p_reg    [1:DIST_W-1];

    for (genvar i = 0; i < DIST_W; i++) begin : g_bit
        localparam int K = DIST_W - 1 - i;

        logic              v_cur;
        meta_t             m_cur;
        logic [R_W-1:0]    r_cur;
        logic [P_W-1:0]    p_cur;
        logic [DIST_W-1:0] q_cur;
        logic [T_W-1:0]    t;
        logic              fit;

        if (i == 0) begin : g_first
            assign v_cur = in_valid;
            assign m_cur = in_meta;
            assign r_cur = in_rem;
            assign p_cur = '0;
            assign q_cur = '0;
        end else begin : g_next
            assign v_cur = v_reg[i];
            assign m_cur = meta_reg[i];
            assign r_cur = r_reg[i];
            assign p_cur = p_reg[i];
            assign q_cur = q_reg[i];
        end

        assign t   = (T_W'(p_cur) << (K + 1)) + (T_W'(norm) << (2 * K));
        assign fit = T_W'(r_cur) >= t;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (adv) begin
                v_reg[i+1] <= v_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                meta_reg[i+1] <= m_cur;
                q_reg[i+1]    <= fit ? (q_cur | (DIST_W'(1) << K)) : q_cur;
            end
        end

        if (i < DIST_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (adv) begin
                    r_reg[i+1] <= fit ? (r_cur - t[R_W-1:0]) : r_cur;
                    p_reg[i+1] <= fit ? (p_cur + (P_W'(norm) << K)) : p_cur;
                end
            end
        end
    end

    assign out_valid = v_reg[DIST_W];
    assign out_meta  = meta_reg[DIST_W];
    assign out_dist  = q_reg[DIST_W];

endmodule

/* design/point_plane_distance_side.sv */
// Pipeline: 2 dot-product stages, 2 squaring stages and one stage per distance
// bit for 49 bits between the input request and the result.
// Throughput: one point per cycle; the whole pipeline holds while the
// result register is full and not taken.
// Reset: synchronous active-low aresetn clears all valid bits and sets the
// plane coefficient and tolerance registers to zero.
// -----------------------------------------------------------------------------
// point_plane_distance_side
// Streams points through a plane value, side test and exact fixed-point
// perpendicular distance pipeline.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module point_plane_distance_side
    import ppds_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // point_x, point_y, point_z
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // plane_value, distance_q8, zero pad
    output logic [M_USER_W-1:0]   m_tuser,   // side, degenerate
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic signed [COEF_W-1:0] coef_a_reg, coef_b_reg, coef_c_reg;
    logic signed [OFFS_W-1:0] coef_d_reg;
    logic        [TOL_W-1:0]  tol_reg;
    logic signed [NORM_W-1:0] sqa_reg, sqb_reg, sqc_reg;
    logic        [NORM_W-1:0] norm_reg;

    logic              adv;
    logic              dot_valid, sqr_valid, root_valid;
    meta_t             dot_meta, sqr_meta, root_meta;
    logic [MAG_W-1:0]  dot_mag;
    logic [R_W-1:0]    sqr_rem;
    logic [DIST_W-1:0] root_dist;
    logic [DIST_W-1:0] dist_out;

    assign cfg_ready = 1'b1;
    assign adv       = m_tready || !m_tvalid;
    assign s_tready  = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_a_reg <= '0;
            coef_b_reg <= '0;
            coef_c_reg <= '0;
            coef_d_reg <= '0;
            tol_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_COEF_A: coef_a_reg <= cfg_data[COEF_W-1:0];
                CFG_COEF_B: coef_b_reg <= cfg_data[COEF_W-1:0];
                CFG_COEF_C: coef_c_reg <= cfg_data[COEF_W-1:0];
                CFG_COEF_D: coef_d_reg <= cfg_data[OFFS_W-1:0];
                CFG_TOL:    tol_reg    <= cfg_data[TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        sqa_reg  <= coef_a_reg * coef_a_reg;
        sqb_reg  <= coef_b_reg * coef_b_reg;
        sqc_reg  <= coef_c_reg * coef_c_reg;
        norm_reg <= NORM_W'(sqa_reg) + NORM_W'(sqb_reg) + NORM_W'(sqc_reg);
    end

    ppds_dot u_dot (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .in_valid     (s_tvalid && s_tready),
        .point_x      (s_tdata[COORD_WIDTH-1:0]),
        .point_y      (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .point_z      (s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
        .coef_a       (coef_a_reg),
        .coef_b       (coef_b_reg),
        .coef_c       (coef_c_reg),
        .coef_d       (coef_d_reg),
        .on_tolerance (tol_reg),
        .out_valid    (dot_valid),
        .out_meta     (dot_meta),
        .out_mag      (dot_mag)
    );

    ppds_sqr u_sqr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (dot_valid),
        .in_meta   (dot_meta),
        .in_mag    (dot_mag),
        .out_valid (sqr_valid),
        .out_meta  (sqr_meta),
        .out_rem   (sqr_rem)
    );

    ppds_root u_root (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .norm      (norm_reg),
        .in_valid  (sqr_valid),
        .in_meta   (sqr_meta),
        .in_rem    (sqr_rem),
        .out_valid (root_valid),
        .out_meta  (root_meta),
        .out_dist  (root_dist)
    );

    assign dist_out = root_meta.degen ? '0 : root_dist;
    assign m_tvalid = root_valid;
    assign m_tdata  = {{(M_DATA_W - VAL_W - DIST_W){1'b0}}, dist_out, root_meta.value};
    assign m_tuser  = {root_meta.degen, root_meta.side};

    `ASSERT_PROP(a_degen_zero, aclk, aresetn, m_tvalid && m_tuser[2] |-> dist_out == '0)
    `ASSERT_PROP(a_above_pos, aclk, aresetn,
                 m_tvalid && root_meta.side == SIDE_ABOVE |-> !root_meta.value[VAL_W-1])
    `ASSERT_PROP(a_below_neg, aclk, aresetn,
                 m_tvalid && root_meta.side == SIDE_BELOW |-> root_meta.value[VAL_W-1])
    `ASSERT_NEVER(a_no_input_in_stall, aclk, aresetn, s_tready && m_tvalid && !m_tready)

endmodule

/* dv/point_plane_distance_side_test.sv */
// -----------------------------------------------------------------------------
// point_plane_distance_side_test
// Streams points through the point-plane distance block and compares the
// plane value, fixed-point distance, side and degenerate flag of every result
// with a predictor that computes them from its own copy of the plane registers.
// -----------------------------------------------------------------------------
module point_plane_distance_side_test
    import ppds_pkg::*;
();

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [DIST_W-1:0] distance;
        side_t             side;
        logic              degen;
    } plane_result_t;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    point_plane_distance_side dut (.*);

    logic signed [COEF_W-1:0] plane_a, plane_b, plane_c;
    logic signed [OFFS_W-1:0] plane_d;
    logic [TOL_W-1:0]         plane_tol;

    plane_result_t expected_results[$];
    int  error_count;
    int  point_count;
    int  result_count;
    int  idle_cycles;
    bit  quiet_mode;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic plane_result_t predict_plane(input logic [S_DATA_W-1:0] pt);
        logic signed [63:0] px, py, pz, val;
        logic [63:0]  mag, norm2;
        logic [255:0] rhs, lhs;
        logic [DIST_W-1:0] dist_acc, cand;
        plane_result_t r;
        px = 64'(signed'(pt[COORD_WIDTH-1:0]));
        py = 64'(signed'(pt[2*COORD_WIDTH-1:COORD_WIDTH]));
        pz = 64'(signed'(pt[3*COORD_WIDTH-1:2*COORD_WIDTH]));
        val = 64'(plane_a) * px + 64'(plane_b) * py + 64'(plane_c) * pz + 64'(plane_d);
        mag = (val < 0) ? 64'(-val) : 64'(val);
        norm2 = 64'(64'(plane_a) * 64'(plane_a)) + 64'(64'(plane_b) * 64'(plane_b))
              + 64'(64'(plane_c) * 64'(plane_c));
        dist_acc = '0;
        if (norm2 != 0) begin
            rhs = (256'(mag) * 256'(mag)) << (2 * FRAC_BITS);
            for (int bit_pos = DIST_W - 1; bit_pos >= 0; bit_pos--) begin
                cand = dist_acc | (DIST_W'(1) << bit_pos);
                lhs = 256'(cand) * 256'(cand) * 256'(norm2);
                if (lhs <= rhs) dist_acc = cand;
            end
        end
        r.value    = val[VAL_W-1:0];
        r.distance = dist_acc;
        r.degen    = (norm2 == 0);
        if (mag <= 64'(plane_tol)) r.side = SIDE_ON;
        else if (val > 0)          r.side = SIDE_ABOVE;
        else                       r.side = SIDE_BELOW;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on result %0d: %s got %h expected %h",
                 result_count, what, got, want);
        error_count++;
    endtask

    task automatic send_point(input logic signed [COORD_WIDTH-1:0] x,
                              input logic signed [COORD_WIDTH-1:0] y,
                              input logic signed [COORD_WIDTH-1:0] z);
        if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({z, y, x});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(predict_plane(S_DATA_W'({z, y, x})));
        point_count++;
        @(negedge aclk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_COEF_A: plane_a = data[COEF_W-1:0];
            CFG_COEF_B: plane_b = data[COEF_W-1:0];
            CFG_COEF_C: plane_c = data[COEF_W-1:0];
            CFG_COEF_D: plane_d = data[OFFS_W-1:0];
            CFG_TOL:    plane_tol = data[TOL_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic set_plane(input logic [COEF_W-1:0] a, input logic [COEF_W-1:0] b,
                             input logic [COEF_W-1:0] c, input logic [OFFS_W-1:0] d,
                             input logic [TOL_W-1:0] tol);
        drain_results();
        write_register(CFG_COEF_A, CFG_DATA_W'(a));
        write_register(CFG_COEF_B, CFG_DATA_W'(b));
        write_register(CFG_COEF_C, CFG_DATA_W'(c));
        write_register(CFG_COEF_D, CFG_DATA_W'(d));
        write_register(CFG_TOL, CFG_DATA_W'(tol));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_point();
        logic [COORD_WIDTH-1:0] x, y, z;
        x = COORD_WIDTH'($urandom);
        y = COORD_WIDTH'($urandom);
        z = COORD_WIDTH'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            x = COORD_WIDTH'($urandom_range(0, 7) - 4);
            y = COORD_WIDTH'($urandom_range(0, 7) - 4);
            z = COORD_WIDTH'($urandom_range(0, 7) - 4);
        end
        send_point(x, y, z);
    endtask

    task automatic random_plane();
        logic [COEF_W-1:0] a, b, c;
        logic [OFFS_W-1:0] d;
        a = COEF_W'($urandom);
        b = COEF_W'($urandom);
        c = COEF_W'($urandom);
        d = OFFS_W'({$urandom, $urandom});
        case ($urandom_range(0, 4))
            0: begin
                a = COEF_W'($urandom_range(0, 4) - 2);
                b = COEF_W'($urandom_range(0, 4) - 2);
            end
            1: d = OFFS_W'(signed'(COEF_W'($urandom)));
            2: begin a = '0; b = '0; c = '0; end
            default: ;
        endcase
        set_plane(a, b, c, d, (TOL_W)'($urandom_range(0, 3) == 0 ? $urandom : 0));
    endtask

    task automatic test_origin_and_degenerate();
        set_plane('0, '0, '0, '0, '0);
        send_point(0, 0, 0);
        send_point(16'sh7fff, -16'sh8000, 5);
        set_plane('0, '0, '0, 40'h80_0000_0000, TOL_W'(20'hfffff));
        send_point(0, 0, 0);
        set_plane('0, '0, '0, 40'h7f_ffff_ffff, '0);
        send_point(-1, -1, -1);
    endtask

    task automatic test_extremes();
        set_plane(16'h8000, 16'h8000, 16'h8000, 40'h80_0000_0000, '0);
        send_point(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_point(-16'sh8000, -16'sh8000, -16'sh8000);
        set_plane(16'h7fff, 16'h7fff, 16'h7fff, 40'h7f_ffff_ffff, 20'hfffff);
        send_point(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_point(-16'sh8000, -16'sh8000, -16'sh8000);
        send_point(0, 0, 0);
        // A unit normal with a huge offset gives a very large distance.
        set_plane(16'd1, '0, '0, 40'h7f_ffff_ffff, '0);
        send_point(16'sh7fff, 0, 0);
        set_plane(16'd1, '0, '0, 40'h80_0000_0000, '0);
        send_point(-16'sh8000, 0, 0);
    endtask

    task automatic test_side_tolerance();
        set_plane('0, '0, 16'd1, '0, 20'd3);
        for (int k = -5; k <= 5; k++) send_point(0, 0, COORD_WIDTH'(k));
        set_plane(16'd3, 16'd4, '0, '0, '0);
        send_point(4, -3, 9);
        send_point(1, 1, 0);
    endtask

    task automatic test_random_planes(input int rounds, input int per_round);
        for (int r = 0; r < rounds; r++) begin
            random_plane();
            repeat (per_round) send_random_point();
        end
    endtask

    always @(posedge aclk) begin
        plane_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_tdata[VAL_W-1:0]), '0);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[VAL_W-1:0] !== want.value)
                    report_mismatch("plane_value", 64'(m_tdata[VAL_W-1:0]), 64'(want.value));
                if (m_tdata[VAL_W+DIST_W-1:VAL_W] !== want.distance)
                    report_mismatch("distance_q8", 64'(m_tdata[VAL_W+DIST_W-1:VAL_W]),
                                    64'(want.distance));
                if (m_tuser[1:0] !== want.side)
                    report_mismatch("side", 64'(m_tuser[1:0]), 64'(want.side));
                if (m_tuser[2] !== want.degen)
                    report_mismatch("degenerate", 64'(m_tuser[2]), 64'(want.degen));
            end
            result_count++;
        end
    end

    always @(negedge aclk) begin
        if (quiet_mode) begin
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_COEF_A;
        cfg_data = '0;
        plane_a = '0;
        plane_b = '0;
        plane_c = '0;
        plane_d = '0;
        plane_tol = '0;
        error_count = 0;
        point_count = 0;
        result_count = 0;
        idle_cycles = 0;
        quiet_mode = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_origin_and_degenerate();
        test_extremes();
        test_side_tolerance();
        test_random_planes(30, 32);
        quiet_mode = 1'b1;
        test_random_planes(4, 40);
        drain_results();
        $display("Sent %0d points over directed and random planes; checked %0d results.",
                 point_count, result_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+design
design/ppds_pkg.sv
design/ppds_dot.sv
design/ppds_sqr.sv
design/ppds_root.sv
design/point_plane_distance_side.sv
dv/point_plane_distance_side_test.sv
